/* src/head_model_coefficient_interpolator_defines.svh */
// Assertion helpers shared by the interpolator RTL.
`ifndef HEAD_MODEL_COEFFICIENT_INTERPOLATOR_DEFINES_SVH
`define HEAD_MODEL_COEFFICIENT_INTERPOLATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HMCI_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HMCI_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/hmci_pkg.sv */
`timescale 1ns / 1ps

package hmci_pkg;

    // Datapath widths.
    localparam int ACC_W      = 51;   // numerator and denominator accumulators
    localparam int ADDR_W     = 8;    // flat table address before trimming
    localparam int ANGLE_STEP = 2560; // 10 degrees in Q8.8
    localparam int RECIP_5    = 205;  // ceil(1024 / 5) for a divide by five

    localparam logic signed [31:0] Q31_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q31_MIN = 32'sh8000_0000;

    // Operation codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // Table codes.
    localparam logic [1:0] TBL_DC   = 2'd0;
    localparam logic [1:0] TBL_HIGH = 2'd1;
    localparam logic [1:0] TBL_CUT  = 2'd2;

    // Columns per row, angle included.
    localparam logic [2:0] COLS_GAIN = 3'd5;
    localparam logic [2:0] COLS_CUT  = 3'd6;

    // Status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_CLAMP = 2'd1;
    localparam logic [1:0] STATUS_SAT   = 2'd2;

    // Multiplier operand for a coefficient term.
    typedef enum logic [1:0] {
        XSEL_P,
        XSEL_P2,
        XSEL_ONE
    } hmci_xsel_t;

    typedef struct packed {
        logic       to_den;
        hmci_xsel_t xsel;
    } hmci_role_t;

    typedef struct packed {
        logic              sat;
        logic signed [31:0] quot;
    } hmci_div_res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_ROW,
        S_FETCH,
        S_DRAIN,
        S_DIV,
        S_DIV_WAIT,
        S_FRAC,
        S_FRAC_WAIT,
        S_MUL,
        S_SUM,
        S_DONE
    } hmci_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_CHECK,
        DIV_ITER,
        DIV_FINISH
    } hmci_div_state_t;

    // Where a coefficient column goes and what it multiplies.
    function automatic hmci_role_t col_role(input logic cut, input logic [2:0] col);
        hmci_role_t role;
        role = '{to_den: 1'b0, xsel: XSEL_ONE};
        if (cut) begin
            case (col)
                3'd1: role = '{to_den: 1'b0, xsel: XSEL_P2};
                3'd2: role = '{to_den: 1'b0, xsel: XSEL_P};
                3'd3: role = '{to_den: 1'b0, xsel: XSEL_ONE};
                3'd4: role = '{to_den: 1'b1, xsel: XSEL_P};
                3'd5: role = '{to_den: 1'b1, xsel: XSEL_ONE};
                default: role = '{to_den: 1'b0, xsel: XSEL_ONE};
            endcase
        end else begin
            case (col)
                3'd1: role = '{to_den: 1'b0, xsel: XSEL_P};
                3'd2: role = '{to_den: 1'b0, xsel: XSEL_ONE};
                3'd3: role = '{to_den: 1'b1, xsel: XSEL_P};
                3'd4: role = '{to_den: 1'b1, xsel: XSEL_ONE};
                default: role = '{to_den: 1'b0, xsel: XSEL_ONE};
            endcase
        end
        return role;
    endfunction

endpackage

/* src/hmci_ram.sv */
`timescale 1ns / 1ps

module hmci_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 160
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port with a registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/hmci_div.sv */
`timescale 1ns / 1ps

module hmci_div
    import hmci_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] num,
    input  logic signed [ACC_W-1:0] den,
    output logic                    done,
    output hmci_div_res_t           res
);

    hmci_div_state_t  state_reg, state_next;
    logic [ACC_W-1:0] a_reg, a_next;
    logic [ACC_W-1:0] b_reg, b_next;
    logic             neg_reg, neg_next;
    logic             pos_reg, pos_next;
    logic [ACC_W-1:0] rem_reg, rem_next;
    logic [31:0]      sh_reg, sh_next;
    logic [31:0]      q_reg, q_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             done_reg, done_next;
    hmci_div_res_t    res_reg, res_next;

    logic [ACC_W:0]    trial;
    logic [ACC_W+15:0] a_wide;
    logic [ACC_W+15:0] b_wide;

    assign trial  = {rem_reg, sh_reg[31]};
    assign a_wide = {16'b0, a_reg};
    assign b_wide = {b_reg, 16'b0};

    // Sign handling, zero-divisor and overflow check, then one quotient bit per cycle.
    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        neg_next   = neg_reg;
        pos_next   = pos_reg;
        rem_next   = rem_reg;
        sh_next    = sh_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    a_next     = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
                    b_next     = den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
                    neg_next   = num[ACC_W-1] ^ den[ACC_W-1];
                    pos_next   = !num[ACC_W-1];
                    state_next = DIV_CHECK;
                end
            end
            DIV_CHECK:
            begin
                if (b_reg == '0)
                begin
                    done_next     = 1'b1;
                    res_next.sat  = 1'b1;
                    res_next.quot = pos_reg ? Q31_MAX : Q31_MIN;
                    state_next    = DIV_IDLE;
                end else if (a_wide >= b_wide)
                begin
                    // Integer part would need more than 16 bits.
                    done_next     = 1'b1;
                    res_next.sat  = 1'b1;
                    res_next.quot = neg_reg ? Q31_MIN : Q31_MAX;
                    state_next    = DIV_IDLE;
                end else
                begin
                    rem_next   = ACC_W'(a_reg >> 16);
                    sh_next    = {a_reg[15:0], 16'b0};
                    q_next     = '0;
                    cnt_next   = 5'd31;
                    state_next = DIV_ITER;
                end
            end
            DIV_ITER:
            begin
                if (trial >= {1'b0, b_reg})
                begin
                    rem_next = ACC_W'(trial - {1'b0, b_reg});
                    q_next   = {q_reg[30:0], 1'b1};
                end else
                begin
                    rem_next = trial[ACC_W-1:0];
                    q_next   = {q_reg[30:0], 1'b0};
                end
                sh_next = {sh_reg[30:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    state_next = DIV_FINISH;
                end else
                begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            DIV_FINISH:
            begin
                done_next = 1'b1;
                if (!neg_reg)
                begin
                    res_next.sat  = q_reg[31];
                    res_next.quot = q_reg[31] ? Q31_MAX : $signed(q_reg);
                end else
                begin
                    res_next.sat  = (q_reg > 32'h8000_0000);
                    res_next.quot = (q_reg > 32'h8000_0000) ? Q31_MIN : $signed(-q_reg);
                end
                state_next = DIV_IDLE;
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            done_reg  <= 1'b0;
        end else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        neg_reg <= neg_next;
        pos_reg <= pos_next;
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

/* src/head_model_coefficient_interpolator.sv */
`timescale 1ns / 1ps

// Head-model coefficient interpolator. Three coefficient tables (DC gain, high-frequency
// gain, shelving cutoff) sit in single-port RAMs, one row per 10-degree step, and are
// loaded one word per write transfer; writes are taken every cycle while the block is
// idle. An evaluate transfer fits each table at the two rows around the angle and
// interpolates by angle, all three quantities in turn. All quotients come from one shared
// radix-2 divider: an angle between rows needs three quotients per table, and an exact
// row angle one quotient per table. A finished result waits in the output register while
// the next transfer is taken in. Reading a word that was never written gives undefined
// results.

module head_model_coefficient_interpolator
    import hmci_pkg::*;
#(
    parameter int TABLE_ROWS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic [1:0]         table_select,
    input  logic [4:0]         row_index,
    input  logic [2:0]         column_index,
    input  logic signed [31:0] table_word,
    input  logic [23:0]        distance_ratio,
    input  logic [15:0]        incidence_angle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] dc_gain_out,
    output logic signed [31:0] high_gain_out,
    output logic signed [31:0] cutoff_out,
    output logic [1:0]         status
);

`include "head_model_coefficient_interpolator_defines.svh"

    localparam int GAIN_DEPTH = 5 * TABLE_ROWS;
    localparam int CUT_DEPTH  = 6 * TABLE_ROWS;
    localparam int GAIN_AW    = $clog2(GAIN_DEPTH);
    localparam int CUT_AW     = $clog2(CUT_DEPTH);
    localparam int ANGLE_LIM  = (TABLE_ROWS - 1) * ANGLE_STEP;

    // Control state.
    hmci_state_t state_reg, state_next;
    logic [1:0]  tbl_reg, tbl_next;
    logic        row_sel_reg, row_sel_next;
    logic [2:0]  col_reg, col_next;
    logic        rd_vld_reg, rd_vld_next;
    logic [2:0]  rd_col_reg, rd_col_next;
    logic        mul_vld_reg, mul_vld_next;
    logic        out_valid_reg, out_valid_next;

    // Datapath registers.
    logic [23:0]              p_reg, p_next;
    logic [31:0]              p2_reg, p2_next;
    logic [15:0]              a_reg, a_next;
    logic                     clamp_reg, clamp_next;
    logic                     sat_reg, sat_next;
    logic                     mul_den_reg, mul_den_next;
    logic signed [48:0]       prod_reg, prod_next;
    logic signed [ACC_W-1:0]  num_reg, num_next;
    logic signed [ACC_W-1:0]  den_reg, den_next;
    logic signed [31:0]       th0_reg, th0_next;
    logic signed [31:0]       th1_reg, th1_next;
    logic signed [31:0]       g0_reg, g0_next;
    logic signed [31:0]       g1_reg, g1_next;
    logic signed [31:0]       f_reg, f_next;
    logic signed [64:0]       mix_reg, mix_next;
    logic signed [31:0]       res_reg [3];
    logic signed [31:0]       res_next [3];
    logic signed [31:0]       dc_out_reg, dc_out_next;
    logic signed [31:0]       high_out_reg, high_out_next;
    logic signed [31:0]       cut_out_reg, cut_out_next;
    logic [1:0]               status_reg, status_next;

    // Combinational helpers.
    logic                    accept;
    logic                    wr_ok;
    logic                    dc_we, high_we, cut_we;
    logic [2:0]              wr_cols, cols_cur;
    logic [ADDR_W-1:0]       wr_addr, rd_addr, ram_addr;
    logic [14:0]             i0_prod;
    logic [4:0]              i0, row_rd;
    logic                    exact;
    logic [31:0]             dc_rdata, high_rdata, cut_rdata, rdata_sel;
    hmci_role_t              role;
    logic signed [32:0]      x_op;
    logic signed [64:0]      mul_full;
    logic signed [ACC_W-1:0] frac_num, frac_den, div_num, div_den;
    logic signed [32:0]      diff;
    logic signed [49:0]      sum_w;
    logic                    sum_ovf;
    logic                    div_start, div_done;
    hmci_div_res_t           div_res;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // Table writes, out-of-range ones dropped.
    assign wr_ok   = accept && (opcode == OP_WRITE) && ({1'b0, row_index} < 6'(TABLE_ROWS));
    assign dc_we   = wr_ok && (table_select == TBL_DC) && (column_index < COLS_GAIN);
    assign high_we = wr_ok && (table_select == TBL_HIGH) && (column_index < COLS_GAIN);
    assign cut_we  = wr_ok && (table_select == TBL_CUT) && (column_index < COLS_CUT);
    assign wr_cols = (table_select == TBL_CUT) ? COLS_CUT : COLS_GAIN;
    assign wr_addr = ADDR_W'(row_index) * ADDR_W'(wr_cols) + ADDR_W'(column_index);

    // Lower bracketing row: angle / 2560 as (angle >> 9) / 5.
    assign i0_prod = 15'(a_reg[15:9]) * 15'(RECIP_5);
    assign i0      = i0_prod[14:10];
    assign exact   = ({1'b0, a_reg} == 17'(i0) * 17'(ANGLE_STEP));
    assign row_rd  = i0 + 5'(row_sel_reg);

    // Row reads while busy.
    assign cols_cur = (tbl_reg == TBL_CUT) ? COLS_CUT : COLS_GAIN;
    assign rd_addr  = ADDR_W'(row_rd) * ADDR_W'(cols_cur) + ADDR_W'(col_reg);
    assign ram_addr = in_ready ? wr_addr : rd_addr;

    hmci_ram #(
        .WIDTH(32),
        .DEPTH(GAIN_DEPTH)
    ) u_dc_ram (
        .clk  (clk),
        .we   (dc_we),
        .addr (ram_addr[GAIN_AW-1:0]),
        .wdata(table_word),
        .rdata(dc_rdata)
    );

    hmci_ram #(
        .WIDTH(32),
        .DEPTH(GAIN_DEPTH)
    ) u_high_ram (
        .clk  (clk),
        .we   (high_we),
        .addr (ram_addr[GAIN_AW-1:0]),
        .wdata(table_word),
        .rdata(high_rdata)
    );

    hmci_ram #(
        .WIDTH(32),
        .DEPTH(CUT_DEPTH)
    ) u_cut_ram (
        .clk  (clk),
        .we   (cut_we),
        .addr (ram_addr[CUT_AW-1:0]),
        .wdata(table_word),
        .rdata(cut_rdata)
    );

    // Term multiplier: coefficient times p, p squared or one.
    always_comb
    begin
        case (tbl_reg)
            TBL_DC:   rdata_sel = dc_rdata;
            TBL_HIGH: rdata_sel = high_rdata;
            default:  rdata_sel = cut_rdata;
        endcase
    end

    assign role = col_role(tbl_reg == TBL_CUT, rd_col_reg);

    always_comb
    begin
        case (role.xsel)
            XSEL_P:  x_op = $signed({9'b0, p_reg});
            XSEL_P2: x_op = $signed({1'b0, p2_reg});
            default: x_op = 33'sd65536;
        endcase
    end

    assign mul_full = 65'($signed(rdata_sel)) * 65'(x_op);

    // Angle fraction operands and the shared divider.
    assign frac_num = ACC_W'($signed({1'b0, a_reg, 8'b0})) - ACC_W'(th0_reg);
    assign frac_den = ACC_W'(th1_reg) - ACC_W'(th0_reg);
    assign div_num  = (state_reg == S_FRAC) ? frac_num : num_reg;
    assign div_den  = (state_reg == S_FRAC) ? frac_den : den_reg;
    assign div_start = (state_reg == S_DIV) || (state_reg == S_FRAC);

    hmci_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (div_num),
        .den  (div_den),
        .done (div_done),
        .res  (div_res)
    );

    // Interpolation sum and its range check.
    assign diff    = 33'(g1_reg) - 33'(g0_reg);
    assign sum_w   = 50'(g0_reg) + 50'($signed(mix_reg[64:16]));
    assign sum_ovf = !((sum_w[49:31] == '0) || (sum_w[49:31] == '1));

    // Sequencer and datapath next state.
    always_comb
    begin
        state_next     = state_reg;
        tbl_next       = tbl_reg;
        row_sel_next   = row_sel_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg;
        p_next         = p_reg;
        p2_next        = p2_reg;
        a_next         = a_reg;
        clamp_next     = clamp_reg;
        sat_next       = sat_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        th0_next       = th0_reg;
        th1_next       = th1_reg;
        g0_next        = g0_reg;
        g1_next        = g1_reg;
        f_next         = f_reg;
        mix_next       = mix_reg;
        res_next       = res_reg;
        dc_out_next    = dc_out_reg;
        high_out_next  = high_out_reg;
        cut_out_next   = cut_out_reg;
        status_next    = status_reg;
        prod_next      = prod_reg;
        mul_den_next   = mul_den_reg;

        // Read, multiply and accumulate stages of a row fetch.
        rd_vld_next  = (state_reg == S_FETCH);
        rd_col_next  = col_reg;
        mul_vld_next = rd_vld_reg && (rd_col_reg != 3'd0);
        if (rd_vld_reg)
        begin
            if (rd_col_reg == 3'd0)
            begin
                if (row_sel_reg)
                begin
                    th1_next = $signed(rdata_sel);
                end else
                begin
                    th0_next = $signed(rdata_sel);
                end
            end else
            begin
                prod_next    = mul_full[64:16];
                mul_den_next = role.to_den;
            end
        end
        if (mul_vld_reg)
        begin
            if (mul_den_reg)
            begin
                den_next = den_reg + ACC_W'(prod_reg);
            end else
            begin
                num_next = num_reg + ACC_W'(prod_reg);
            end
        end

        // Result transfer frees the output register.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (opcode == OP_EVAL))
                begin
                    p_next     = distance_ratio;
                    clamp_next = (17'(incidence_angle) > 17'(ANGLE_LIM));
                    a_next     = (17'(incidence_angle) > 17'(ANGLE_LIM)) ? 16'(ANGLE_LIM)
                                                                         : incidence_angle;
                    sat_next   = 1'b0;
                    tbl_next   = TBL_DC;
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                p2_next      = 32'((48'(p_reg) * 48'(p_reg)) >> 16);
                row_sel_next = 1'b0;
                state_next   = S_ROW;
            end
            S_ROW:
            begin
                col_next   = 3'd0;
                num_next   = '0;
                den_next   = ACC_W'(p2_reg);
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                col_next = col_reg + 3'd1;
                if (col_reg == cols_cur - 3'd1)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!rd_vld_reg && !mul_vld_reg)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    sat_next = sat_reg || div_res.sat;
                    if (!row_sel_reg)
                    begin
                        g0_next = div_res.quot;
                        if (exact)
                        begin
                            // Exact row angle: the fit is the result.
                            res_next[tbl_reg] = div_res.quot;
                            if (tbl_reg == TBL_CUT)
                            begin
                                state_next = S_DONE;
                            end else
                            begin
                                tbl_next     = tbl_reg + 2'd1;
                                row_sel_next = 1'b0;
                                state_next   = S_ROW;
                            end
                        end else
                        begin
                            row_sel_next = 1'b1;
                            state_next   = S_ROW;
                        end
                    end else
                    begin
                        g1_next    = div_res.quot;
                        state_next = S_FRAC;
                    end
                end
            end
            S_FRAC:
            begin
                state_next = S_FRAC_WAIT;
            end
            S_FRAC_WAIT:
            begin
                if (div_done)
                begin
                    sat_next   = sat_reg || div_res.sat;
                    f_next     = div_res.quot;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                mix_next   = diff * f_reg;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                if (sum_ovf)
                begin
                    sat_next          = 1'b1;
                    res_next[tbl_reg] = sum_w[49] ? Q31_MIN : Q31_MAX;
                end else
                begin
                    res_next[tbl_reg] = sum_w[31:0];
                end
                if (tbl_reg == TBL_CUT)
                begin
                    state_next = S_DONE;
                end else
                begin
                    tbl_next     = tbl_reg + 2'd1;
                    row_sel_next = 1'b0;
                    state_next   = S_ROW;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    dc_out_next    = res_reg[TBL_DC];
                    high_out_next  = res_reg[TBL_HIGH];
                    cut_out_next   = res_reg[TBL_CUT];
                    status_next    = sat_reg ? STATUS_SAT : (clamp_reg ? STATUS_CLAMP : STATUS_OK);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tbl_reg       <= TBL_DC;
            row_sel_reg   <= 1'b0;
            col_reg       <= 3'd0;
            rd_vld_reg    <= 1'b0;
            rd_col_reg    <= 3'd0;
            mul_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else
        begin
            state_reg     <= state_next;
            tbl_reg       <= tbl_next;
            row_sel_reg   <= row_sel_next;
            col_reg       <= col_next;
            rd_vld_reg    <= rd_vld_next;
            rd_col_reg    <= rd_col_next;
            mul_vld_reg   <= mul_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        p2_reg       <= p2_next;
        a_reg        <= a_next;
        clamp_reg    <= clamp_next;
        sat_reg      <= sat_next;
        mul_den_reg  <= mul_den_next;
        prod_reg     <= prod_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        th0_reg      <= th0_next;
        th1_reg      <= th1_next;
        g0_reg       <= g0_next;
        g1_reg       <= g1_next;
        f_reg        <= f_next;
        mix_reg      <= mix_next;
        res_reg      <= res_next;
        dc_out_reg   <= dc_out_next;
        high_out_reg <= high_out_next;
        cut_out_reg  <= cut_out_next;
        status_reg   <= status_next;
    end

    assign out_valid     = out_valid_reg;
    assign dc_gain_out   = dc_out_reg;
    assign high_gain_out = high_out_reg;
    assign cutoff_out    = cut_out_reg;
    assign status        = status_reg;

    // Table writes only happen while no evaluate is running.
    `HMCI_ASSERT_SAME(a_write_when_idle, dc_we || high_we || cut_we, state_reg == S_IDLE, "table write while busy")
    // A write transfer loads at most one table.
    `HMCI_ASSERT_SAME(a_single_write, 1'b1, $onehot0({dc_we, high_we, cut_we}), "more than one table written")
    // The row fetch pipeline is empty before its quotient is started.
    `HMCI_ASSERT_SAME(a_fetch_drained, state_reg == S_DIV, !rd_vld_reg && !mul_vld_reg, "divide started before row accumulated")
    // The angle fraction is only formed between two distinct rows.
    `HMCI_ASSERT_SAME(a_frac_between_rows, state_reg == S_FRAC, !exact && row_sel_reg, "fraction at an exact row angle")
    // A finished evaluate always lands in the output register.
    `HMCI_ASSERT_NEXT(a_result_loaded, state_reg == S_DONE && (!out_valid_reg || out_ready), out_valid_reg && state_reg == S_IDLE, "result not loaded")

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench
    import hmci_pkg::*;
();

    localparam int ROWS       = 32;
    localparam int ROW_ANGLE  = 655360;  // 10 degrees in Q16.16
    localparam int WATCH_MAX  = 20000;
    localparam int SHOW_MAX   = 10;

    // One stimulus transfer, with an optional expected status set by the test.
    typedef struct {
        logic               op;
        logic [1:0]         sel;
        logic [4:0]         row;
        logic [2:0]         col;
        logic signed [31:0] word;
        logic [23:0]        ratio;
        logic [15:0]        angle;
        bit                 typed;
        logic [1:0]         typed_status;
    } xfer_t;

    // One expected result.
    typedef struct {
        logic signed [31:0] dc;
        logic signed [31:0] high;
        logic signed [31:0] cut;
        logic [1:0]         st;
        bit                 typed;
        logic [1:0]         typed_status;
    } gains_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               opcode;
    logic [1:0]         table_select;
    logic [4:0]         row_index;
    logic [2:0]         column_index;
    logic signed [31:0] table_word;
    logic [23:0]        distance_ratio;
    logic [15:0]        incidence_angle;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] dc_gain_out;
    logic signed [31:0] high_gain_out;
    logic signed [31:0] cutoff_out;
    logic [1:0]         status;

    // Shadow copies of the three coefficient tables.
    int dc_rows [ROWS*5];
    int high_rows [ROWS*5];
    int cut_rows [ROWS*6];

    gains_t pending_gains [$];
    xfer_t  steps [$];
    int     mismatches;
    int     idle_cycles;
    int     send_gap_pct;
    int     recv_stall_pct;
    bit     next_typed;
    logic [1:0] next_typed_status;

    head_model_coefficient_interpolator #(.TABLE_ROWS(ROWS)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .table_select(table_select), .row_index(row_index),
        .column_index(column_index), .table_word(table_word),
        .distance_ratio(distance_ratio), .incidence_angle(incidence_angle),
        .out_valid(out_valid), .out_ready(out_ready),
        .dc_gain_out(dc_gain_out), .high_gain_out(high_gain_out),
        .cutoff_out(cutoff_out), .status(status)
    );

    always #4 clk = ~clk;

    // Table word read by table code and flat index.
    function automatic longint shadow(input int sel, input int idx);
        if (sel == TBL_DC)
            return dc_rows[idx];
        else if (sel == TBL_HIGH)
            return high_rows[idx];
        return cut_rows[idx];
    endfunction

    function automatic longint coef_term(input longint c, input longint x);
        return (c * x) >>> 16;
    endfunction

    function automatic int clip32(input longint v, inout bit sat);
        if (v > 64'sd2147483647)
        begin
            sat = 1'b1;
            return Q31_MAX;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1'b1;
            return Q31_MIN;
        end
        return int'(v);
    endfunction

    // Q16.16 quotient num/den truncated toward zero, saturating.
    function automatic int q16_quotient(input longint num, input longint den, inout bit sat);
        longint unsigned a, b, q, r;
        bit neg;
        if (den == 0)
        begin
            sat = 1'b1;
            return (num >= 0) ? Q31_MAX : Q31_MIN;
        end
        neg = (num < 0) != (den < 0);
        a = (num < 0) ? -num : num;
        b = (den < 0) ? -den : den;
        q = a / b;
        r = a % b;
        if (q >= 64'd65536)
        begin
            sat = 1'b1;
            return neg ? Q31_MIN : Q31_MAX;
        end
        for (int k = 0; k < 16; k++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= b)
            begin
                r = r - b;
                q = q | 64'd1;
            end
        end
        return clip32(neg ? -longint'(q) : longint'(q), sat);
    endfunction

    // Rational fit of one table row at ratio p.
    function automatic int row_fit(input int sel, input int row, input longint p,
                                   input longint p2, inout bit sat);
        longint num, den;
        int b;
        if (sel == TBL_CUT)
        begin
            b = row * 6;
            num = coef_term(shadow(sel, b+1), p2) + coef_term(shadow(sel, b+2), p)
                + shadow(sel, b+3);
            den = p2 + coef_term(shadow(sel, b+4), p) + shadow(sel, b+5);
        end
        else
        begin
            b = row * 5;
            num = coef_term(shadow(sel, b+1), p) + shadow(sel, b+2);
            den = p2 + coef_term(shadow(sel, b+3), p) + shadow(sel, b+4);
        end
        return q16_quotient(num, den, sat);
    endfunction

    // Fit at the rows around the angle, blended linearly by angle.
    function automatic int angle_blend(input int sel, input int a, input longint p,
                                       input longint p2, inout bit sat);
        int cols, i0, g0, g1, f;
        longint th0, th1;
        cols = (sel == TBL_CUT) ? 6 : 5;
        i0 = a / ANGLE_STEP;
        if (a % ANGLE_STEP == 0)
            return row_fit(sel, i0, p, p2, sat);
        g0 = row_fit(sel, i0, p, p2, sat);
        g1 = row_fit(sel, i0 + 1, p, p2, sat);
        th0 = shadow(sel, cols * i0);
        th1 = shadow(sel, cols * (i0 + 1));
        f = q16_quotient((longint'(a) << 8) - th0, th1 - th0, sat);
        return clip32(longint'(g0) + (((longint'(g1) - longint'(g0)) * longint'(f)) >>> 16),
                      sat);
    endfunction

    // A coefficient of moderate size that keeps the denominators positive.
    function automatic int moderate_word(input int sel, input int col);
        bit den_lin, den_const;
        den_lin = (sel == TBL_CUT) ? (col == 4) : (col == 3);
        den_const = (sel == TBL_CUT) ? (col == 5) : (col == 4);
        if (den_const)
            return $urandom_range(65536, 131072);
        if (den_lin)
            return $urandom_range(0, 65536);
        return int'($urandom_range(0, 131072)) - 65536;
    endfunction

    // Track table writes and predict each evaluate on acceptance.
    always @(posedge clk)
    begin
        gains_t g;
        bit sat;
        bit clamp;
        longint p, p2;
        int a;
        if (rst_n && in_valid && in_ready)
        begin
            if (opcode == OP_WRITE)
            begin
                if (table_select == TBL_DC && column_index < COLS_GAIN)
                    dc_rows[row_index*5 + column_index] = table_word;
                else if (table_select == TBL_HIGH && column_index < COLS_GAIN)
                    high_rows[row_index*5 + column_index] = table_word;
                else if (table_select == TBL_CUT && column_index < COLS_CUT)
                    cut_rows[row_index*6 + column_index] = table_word;
            end
            else
            begin
                sat = 1'b0;
                clamp = 1'b0;
                p = distance_ratio;
                p2 = (p * p) >> 16;
                a = incidence_angle;
                if (a > (ROWS - 1) * ANGLE_STEP)
                begin
                    a = (ROWS - 1) * ANGLE_STEP;
                    clamp = 1'b1;
                end
                g.dc = angle_blend(TBL_DC, a, p, p2, sat);
                g.high = angle_blend(TBL_HIGH, a, p, p2, sat);
                g.cut = angle_blend(TBL_CUT, a, p, p2, sat);
                g.st = sat ? STATUS_SAT : (clamp ? STATUS_CLAMP : STATUS_OK);
                g.typed = next_typed;
                g.typed_status = next_typed_status;
                pending_gains.push_back(g);
            end
        end
    end

    // Compare each result transfer with the oldest prediction.
    always @(posedge clk)
    begin
        gains_t g;
        bit bad;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_gains.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display("unexpected result: dc %h high %h cut %h status %0d",
                             dc_gain_out, high_gain_out, cutoff_out, status);
            end
            else
            begin
                g = pending_gains.pop_front();
                bad = (dc_gain_out !== g.dc) || (high_gain_out !== g.high)
                    || (cutoff_out !== g.cut) || (status !== g.st)
                    || (g.typed && status !== g.typed_status);
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                        $display("mismatch: expected dc %h high %h cut %h status %0d, %s%h %h %h %0d",
                                 g.dc, g.high, g.cut, g.typed ? g.typed_status : g.st,
                                 "got ", dc_gain_out, high_gain_out, cutoff_out, status);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCH_MAX)
        begin
            $display("watchdog: no transfer for %0d cycles", WATCH_MAX);
            $display("** head_model_coefficient_interpolator: FAILED **");
            $finish;
        end
    end

    // Receiver readiness, redrawn every falling edge.
    always @(negedge clk)
    begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Drive one transfer and hold it until it is accepted.
    task automatic send(input xfer_t x);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        next_typed = x.typed;
        next_typed_status = x.typed_status;
        in_valid = 1'b1;
        opcode = x.op;
        table_select = x.sel;
        row_index = x.row;
        column_index = x.col;
        table_word = x.word;
        distance_ratio = x.ratio;
        incidence_angle = x.angle;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    function automatic xfer_t table_write(input int sel, input int row, input int col,
                                          input int word);
        xfer_t x;
        x = '{op: OP_WRITE, sel: sel[1:0], row: row[4:0], col: col[2:0], word: word,
              ratio: 24'($urandom), angle: 16'($urandom), typed: 1'b0,
              typed_status: STATUS_OK};
        return x;
    endfunction

    function automatic xfer_t evaluate(input int ratio, input int angle);
        xfer_t x;
        x = '{op: OP_EVAL, sel: 2'($urandom), row: 5'($urandom), col: 3'($urandom),
              word: $urandom, ratio: ratio[23:0], angle: angle[15:0], typed: 1'b0,
              typed_status: STATUS_OK};
        return x;
    endfunction

    // A random transfer: mostly evaluates, the rest table rewrites and noise.
    function automatic xfer_t random_xfer();
        int kind, sel, row, col;
        sel = $urandom_range(2);
        row = $urandom_range(ROWS - 1);
        col = $urandom_range(1, (sel == TBL_CUT) ? 5 : 4);
        kind = $urandom_range(99);
        if (kind < 70)
            return evaluate(($urandom_range(1)) ? $urandom_range(0, 24'h3FFFF)
                                                : $urandom_range(0, 24'hFFFFFF),
                            ($urandom_range(4) == 0) ? ANGLE_STEP * $urandom_range(25)
                                                     : $urandom_range(0, 16'hFFFF));
        if (kind < 85)
            return table_write(sel, row, col, moderate_word(sel, col));
        if (kind < 90)
            return table_write(sel, row, 0, row * ROW_ANGLE + int'($urandom_range(0, 8192)) - 4096);
        if (kind < 95)
            return table_write(sel, row, $urandom_range(7), $urandom);
        return table_write(3, row, $urandom_range(7), $urandom);
    endfunction

    initial
    begin
        xfer_t x;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_WRITE;
        table_select = TBL_DC;
        row_index = '0;
        column_index = '0;
        table_word = '0;
        distance_ratio = '0;
        incidence_angle = '0;
        out_ready = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        send_gap_pct = 23;
        recv_stall_pct = 56;
        next_typed = 1'b0;
        next_typed_status = STATUS_OK;
        foreach (dc_rows[i]) dc_rows[i] = 0;
        foreach (high_rows[i]) high_rows[i] = 0;
        foreach (cut_rows[i]) cut_rows[i] = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Load every word of every table before any evaluate reads one.
        for (int s = TBL_DC; s <= TBL_CUT; s++)
            for (int r = 0; r < ROWS; r++)
                for (int c = 0; c < ((s == TBL_CUT) ? 6 : 5); c++)
                    send(table_write(s, r, c, (c == 0) ? r * ROW_ANGLE : moderate_word(s, c)));

        // Directed part: zero denominators, equal row angles, extremes, ignored writes.
        x = table_write(TBL_DC, 0, 3, 0);               steps.push_back(x);
        x = table_write(TBL_DC, 0, 4, 0);               steps.push_back(x);
        x = evaluate(0, 0);
        x.typed = 1'b1;
        x.typed_status = STATUS_SAT;                     steps.push_back(x);
        x = table_write(TBL_DC, 0, 3, 32768);           steps.push_back(x);
        x = table_write(TBL_DC, 0, 4, 65536);           steps.push_back(x);
        x = evaluate(0, 0);                              steps.push_back(x);
        x = evaluate(24'hFFFFFF, 0);                     steps.push_back(x);
        x = evaluate(24'hFFFFFF, 16'hFFFF);              steps.push_back(x);
        x = evaluate(0, 16'hFFFF);                       steps.push_back(x);
        x = evaluate(65536, 1);                          steps.push_back(x);
        x = evaluate(65536, ANGLE_STEP - 1);             steps.push_back(x);
        x = evaluate(65536, ANGLE_STEP);                 steps.push_back(x);
        x = evaluate(65536, 25 * ANGLE_STEP);            steps.push_back(x);
        x = table_write(3, 2, 1, -1);                    steps.push_back(x);
        x = table_write(TBL_DC, 2, 5, -1);               steps.push_back(x);
        x = table_write(TBL_CUT, 2, 6, -1);              steps.push_back(x);
        x = table_write(TBL_HIGH, 2, 7, -1);             steps.push_back(x);
        x = table_write(TBL_DC, 1, 0, 0);               steps.push_back(x);
        x = evaluate(65536, 1);
        x.typed = 1'b1;
        x.typed_status = STATUS_SAT;                     steps.push_back(x);
        x = table_write(TBL_DC, 1, 0, ROW_ANGLE);        steps.push_back(x);
        x = table_write(TBL_HIGH, 5, 2, 32'sh7FFF_FFFF); steps.push_back(x);
        x = table_write(TBL_CUT, 5, 3, 32'sh8000_0000);  steps.push_back(x);
        x = evaluate(65536, 5 * ANGLE_STEP + 100);       steps.push_back(x);
        x = evaluate(24'hFFFFFF, 5 * ANGLE_STEP);        steps.push_back(x);
        foreach (steps[i])
            send(steps[i]);

        // Random part in three idling phases; the sender drains between phases.
        for (int ph = 0; ph < 3; ph++)
        begin
            send_gap_pct = (ph == 0) ? 23 : (ph == 1) ? 56 : 0;
            recv_stall_pct = (ph == 0) ? 56 : (ph == 1) ? 23 : 0;
            for (int n = 0; n < 22; n++)
                send(random_xfer());
            wait (pending_gains.size() == 0);
            @(negedge clk);
        end

        wait (pending_gains.size() == 0);
        repeat (500) @(posedge clk);
        if (mismatches == 0 && pending_gains.size() == 0)
            $display("** head_model_coefficient_interpolator: PASSED **");
        else
            $display("** head_model_coefficient_interpolator: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/hmci_pkg.sv
src/hmci_ram.sv
src/hmci_div.sv
src/head_model_coefficient_interpolator.sv
bench/testbench.sv
